[hdl/sha_pkg.sv]
// ============================================================================
// sha_pkg
// Types, codes and constants shared by the SHA-256 stream hash modules.
// ============================================================================
`default_nettype none

package sha_pkg;

	localparam logic [1:0] OP_ABSORB        = 2'd0;
	localparam logic [1:0] OP_ABSORB_FINISH = 2'd1;
	localparam logic [1:0] OP_FINISH        = 2'd2;

	localparam int unsigned PAD_LIMIT = 56;

	typedef struct packed {
		logic [1:0] operation;
		logic [7:0] data_byte;
	} sha_req_t;

	typedef struct packed {
		logic [31:0] digest_word;
		logic [2:0]  word_index;
		logic        last_word;
	} sha_rsp_t;

	typedef logic [7:0][31:0] sha_words_t;

	typedef struct packed {
		logic [6:0]  fill;
		logic        pad;
		logic        len;
		logic [63:0] bit_len;
	} sha_blk_t;

	typedef struct packed {
		logic start;
		logic init;
	} sha_ctl_t;

	localparam sha_words_t SHA_IV = {
		32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
		32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
	};

	function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
		logic [63:0] d;
		d = {x, x} >> n;
		return d[31:0];
	endfunction

	function automatic logic [31:0] round_k(input logic [5:0] t);
		logic [31:0] k;
		case (t)
			6'd0: k = 32'h428a2f98; 6'd1: k = 32'h71374491;
			6'd2: k = 32'hb5c0fbcf; 6'd3: k = 32'he9b5dba5;
			6'd4: k = 32'h3956c25b; 6'd5: k = 32'h59f111f1;
			6'd6: k = 32'h923f82a4; 6'd7: k = 32'hab1c5ed5;
			6'd8: k = 32'hd807aa98; 6'd9: k = 32'h12835b01;
			6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
			6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe;
			6'd14: k = 32'h9bdc06a7; 6'd15: k = 32'hc19bf174;
			6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
			6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc;
			6'd20: k = 32'h2de92c6f; 6'd21: k = 32'h4a7484aa;
			6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
			6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d;
			6'd26: k = 32'hb00327c8; 6'd27: k = 32'hbf597fc7;
			6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
			6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967;
			6'd32: k = 32'h27b70a85; 6'd33: k = 32'h2e1b2138;
			6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
			6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb;
			6'd38: k = 32'h81c2c92e; 6'd39: k = 32'h92722c85;
			6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
			6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3;
			6'd44: k = 32'hd192e819; 6'd45: k = 32'hd6990624;
			6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
			6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08;
			6'd50: k = 32'h2748774c; 6'd51: k = 32'h34b0bcb5;
			6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
			6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3;
			6'd56: k = 32'h748f82ee; 6'd57: k = 32'h78a5636f;
			6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
			6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb;
			6'd62: k = 32'hbef9a3f7; 6'd63: k = 32'hc67178f2;
			default: k = 32'h0;
		endcase
		return k;
	endfunction

endpackage

`default_nettype wire

[hdl/sha_buf_ram.sv]
// ============================================================================
// sha_buf_ram
// Block buffer: sixteen 32-bit words with byte-lane writes, registered read.
// ============================================================================
`default_nettype none

module sha_buf_ram (
	input  wire logic        clk,
	input  wire logic        wr_en,
	input  wire logic [3:0]  wr_addr,
	input  wire logic [1:0]  wr_lane,
	input  wire logic [7:0]  wr_byte,
	input  wire logic [3:0]  rd_addr,
	output logic      [31:0] rd_data
);

	logic [31:0] mem [16];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			case (wr_lane)
				2'd0: mem[wr_addr][31:24] <= wr_byte;
				2'd1: mem[wr_addr][23:16] <= wr_byte;
				2'd2: mem[wr_addr][15:8] <= wr_byte;
				default: mem[wr_addr][7:0] <= wr_byte;
			endcase
		end
		rd_data <= mem[rd_addr];
	end

endmodule

`default_nettype wire

[hdl/sha_core.sv]
// ============================================================================
// sha_core
// SHA-256 compression: one round per cycle, padding inserted on buffer read.
// ============================================================================
`default_nettype none

module sha_core (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire sha_pkg::sha_ctl_t   ctl,
	input  wire sha_pkg::sha_blk_t   blk,
	input  wire logic [31:0]         rd_data,
	output logic      [3:0]          rd_addr,
	output logic                     done,
	output sha_pkg::sha_words_t      chain
);
	import sha_pkg::*;

	localparam logic [1:0] C_IDLE  = 2'd0;
	localparam logic [1:0] C_LOAD  = 2'd1;
	localparam logic [1:0] C_ROUND = 2'd2;
	localparam logic [1:0] C_ADD   = 2'd3;

	logic [1:0]        state_q;
	logic [5:0]        rnd_q;
	sha_words_t        chain_q;
	sha_words_t        work_q;
	logic [15:0][31:0] w_q;

	logic [31:0] msg_word, w_new, sg0, sg1;
	logic [31:0] big_s0, big_s1, ch, mj, t1, t2;
	logic [5:0]  j;
	logic [2:0]  sel;

	always_comb begin
		msg_word = '0;
		for (int k = 0; k < 4; k++) begin
			j = {rnd_q[3:0], 2'(k)};
			sel = {rnd_q[0], 2'(k)};
			if (blk.len && rnd_q[3:0] >= 4'd14) begin
				msg_word[31 - 8 * k -: 8] = blk.bit_len[{~sel, 3'b000} +: 8];
			end else if ({1'b0, j} < blk.fill) begin
				msg_word[31 - 8 * k -: 8] = rd_data[31 - 8 * k -: 8];
			end else if (blk.pad && {1'b0, j} == blk.fill) begin
				msg_word[31 - 8 * k -: 8] = 8'h80;
			end else begin
				msg_word[31 - 8 * k -: 8] = 8'h00;
			end
		end
		sg0 = rotr(w_q[1], 7) ^ rotr(w_q[1], 18) ^ (w_q[1] >> 3);
		sg1 = rotr(w_q[14], 17) ^ rotr(w_q[14], 19) ^ (w_q[14] >> 10);
		w_new = (rnd_q < 6'd16) ? msg_word : sg1 + w_q[9] + sg0 + w_q[0];
		big_s1 = rotr(work_q[4], 6) ^ rotr(work_q[4], 11) ^ rotr(work_q[4], 25);
		ch = (work_q[4] & work_q[5]) ^ (~work_q[4] & work_q[6]);
		t1 = work_q[7] + big_s1 + ch + round_k(rnd_q) + w_new;
		big_s0 = rotr(work_q[0], 2) ^ rotr(work_q[0], 13) ^ rotr(work_q[0], 22);
		mj = (work_q[0] & work_q[1]) ^ (work_q[0] & work_q[2]) ^ (work_q[1] & work_q[2]);
		t2 = big_s0 + mj;
	end

	assign rd_addr = (state_q == C_ROUND) ? rnd_q[3:0] + 4'd1 : 4'd0;
	assign done = (state_q == C_ADD);
	assign chain = chain_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= C_IDLE;
			rnd_q <= '0;
			chain_q <= SHA_IV;
		end else begin
			case (state_q)
				C_IDLE: begin
					if (ctl.start) begin
						state_q <= C_LOAD;
					end
					if (ctl.init) begin
						chain_q <= SHA_IV;
					end
				end
				C_LOAD: begin
					rnd_q <= '0;
					state_q <= C_ROUND;
				end
				C_ROUND: begin
					rnd_q <= rnd_q + 6'd1;
					if (rnd_q == 6'd63) begin
						state_q <= C_ADD;
					end
				end
				default: begin
					for (int i = 0; i < 8; i++) begin
						chain_q[i] <= chain_q[i] + work_q[i];
					end
					state_q <= C_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == C_LOAD) begin
			work_q <= chain_q;
		end else if (state_q == C_ROUND) begin
			w_q <= {w_new, w_q[15:1]};
			work_q[7] <= work_q[6];
			work_q[6] <= work_q[5];
			work_q[5] <= work_q[4];
			work_q[4] <= work_q[3] + t1;
			work_q[3] <= work_q[2];
			work_q[2] <= work_q[1];
			work_q[1] <= work_q[0];
			work_q[0] <= t1 + t2;
		end
	end

endmodule

`default_nettype wire

[hdl/sha256_stream_hash.sv]
// ============================================================================
// sha256_stream_hash
// SHA-256 of a byte stream, at most one message byte per input item.
// ============================================================================
// The req channel takes one item per byte: operation absorbs a byte, absorbs
// a byte and finishes, or finishes without a byte. Bytes go into a 16-word
// block buffer memory. The 64th byte of a block starts a compression: a
// start step, a load step, the 64 rounds and an add step, during which
// req_stall is high. A finish pads on the fly while the buffer is read and
// runs one or two compressions, then the rsp channel gives eight items,
// digest word A first, last_word high on H.
// While rsp_stall is high the current word holds and req stays stalled.
// After the last word is taken the block is as after reset.
// Reset clears all control state and loads the initial chaining values.
// ============================================================================
`default_nettype none

module sha256_stream_hash (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               req_valid,
	output logic                    req_stall,
	input  wire sha_pkg::sha_req_t  req,
	output logic                    rsp_valid,
	input  wire logic               rsp_stall,
	output sha_pkg::sha_rsp_t       rsp
);
	import sha_pkg::*;

	localparam logic [1:0] T_IDLE = 2'd0;
	localparam logic [1:0] T_COMP = 2'd1;
	localparam logic [1:0] T_OUT  = 2'd2;

	logic [1:0]  state_q;
	logic [5:0]  bc_q;
	logic [60:0] cnt_q;
	logic        start_q, fin_q, second_q, last_q, init_q;
	sha_blk_t    blk_q;
	logic [2:0]  idx_q;
	logic        ovalid_q;
	sha_rsp_t    out_q;

	logic        accept, absorb, rsp_take;
	logic [5:0]  fin_n;
	logic [3:0]  rd_addr;
	logic [31:0] rd_data;
	logic        done;
	sha_words_t  chain;
	sha_ctl_t    ctl;

	assign req_stall = (state_q != T_IDLE);
	assign accept = req_valid && !req_stall;
	assign absorb = accept &&
		(req.operation == OP_ABSORB || req.operation == OP_ABSORB_FINISH);
	assign rsp_take = ovalid_q && !rsp_stall;
	assign rsp_valid = ovalid_q;
	assign rsp = out_q;
	assign ctl = '{start: start_q, init: init_q};

	sha_buf_ram u_ram (
		.clk     (clk),
		.wr_en   (absorb),
		.wr_addr (bc_q[5:2]),
		.wr_lane (bc_q[1:0]),
		.wr_byte (req.data_byte),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	sha_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (ctl),
		.blk     (blk_q),
		.rd_data (rd_data),
		.rd_addr (rd_addr),
		.done    (done),
		.chain   (chain)
	);

	assign fin_n = (accept && req.operation == OP_ABSORB_FINISH) ? bc_q + 6'd1 : bc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= T_IDLE;
			bc_q <= '0;
			cnt_q <= '0;
			start_q <= 1'b0;
			fin_q <= 1'b0;
			second_q <= 1'b0;
			last_q <= 1'b0;
			init_q <= 1'b0;
			idx_q <= '0;
			ovalid_q <= 1'b0;
			blk_q <= '0;
		end else begin
			start_q <= 1'b0;
			init_q <= 1'b0;
			case (state_q)
				T_IDLE: begin
					if (absorb) begin
						bc_q <= bc_q + 6'd1;
						cnt_q <= cnt_q + 61'd1;
					end
					if (absorb && bc_q == 6'd63) begin
						blk_q <= '{fill: 7'd64, pad: 1'b0, len: 1'b0, bit_len: '0};
						fin_q <= (req.operation == OP_ABSORB_FINISH);
						start_q <= 1'b1;
						state_q <= T_COMP;
					end else if (accept && (req.operation == OP_ABSORB_FINISH ||
						req.operation == OP_FINISH)) begin
						blk_q <= '{fill: {1'b0, fin_n}, pad: 1'b1,
							len: (fin_n < 6'(PAD_LIMIT)),
							bit_len: {cnt_q + 61'(absorb), 3'b000}};
						second_q <= (fin_n >= 6'(PAD_LIMIT));
						last_q <= (fin_n < 6'(PAD_LIMIT));
						start_q <= 1'b1;
						state_q <= T_COMP;
					end
				end
				T_COMP: begin
					if (done) begin
						if (fin_q) begin
							fin_q <= 1'b0;
							blk_q <= '{fill: 7'd0, pad: 1'b1, len: 1'b1,
								bit_len: {cnt_q, 3'b000}};
							last_q <= 1'b1;
							start_q <= 1'b1;
						end else if (second_q) begin
							second_q <= 1'b0;
							blk_q <= '{fill: 7'd0, pad: 1'b0, len: 1'b1,
								bit_len: {cnt_q, 3'b000}};
							last_q <= 1'b1;
							start_q <= 1'b1;
						end else if (last_q) begin
							last_q <= 1'b0;
							idx_q <= '0;
							state_q <= T_OUT;
						end else begin
							state_q <= T_IDLE;
						end
					end
				end
				T_OUT: begin
					if (!ovalid_q) begin
						ovalid_q <= 1'b1;
					end else if (rsp_take) begin
						if (idx_q == 3'd7) begin
							ovalid_q <= 1'b0;
							bc_q <= '0;
							cnt_q <= '0;
							init_q <= 1'b1;
							state_q <= T_IDLE;
						end else begin
							idx_q <= idx_q + 3'd1;
						end
					end
				end
				default: state_q <= T_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == T_OUT && !ovalid_q) begin
			out_q <= '{digest_word: chain[0], word_index: 3'd0, last_word: 1'b0};
		end else if (rsp_take && idx_q != 3'd7) begin
			out_q <= '{digest_word: chain[idx_q + 3'd1], word_index: idx_q + 3'd1,
				last_word: (idx_q == 3'd6)};
		end
	end

	a_out_only_in_out: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> state_q == T_OUT)
		else $error("result valid outside output phase");
	a_done_while_comp: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> state_q == T_COMP)
		else $error("compression finished while not waiting for it");
	a_clear_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_take && rsp.last_word) |=> (bc_q == 6'd0 && cnt_q == 61'd0))
		else $error("counts not cleared after last digest word");
	a_index_match: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp.word_index == idx_q)
		else $error("digest word index out of step");

endmodule

`default_nettype wire
